// ===== hdl/blsw_pkg.sv =====
// Shared types and constants for the bounded list with search.
// Used by the channel interfaces, the storage cell and the top level.
package blsw_pkg;

    // Payload widths fixed by the item format
    localparam int DATA_W = 32;
    localparam int OP_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W = 4;
    localparam int COUNT_W = 5;

    // Default number of list entries
    localparam int CAPACITY_DEF = 16;

    // Operation codes carried in a request
    typedef enum logic [OP_W-1:0] {
        OP_HEAD = 2'd0,
        OP_TAIL = 2'd1,
        OP_DROP = 2'd2,
        OP_FIND = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Command broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_IN,
        CELL_SHIFT_OUT,
        CELL_APPEND,
        CELL_ROTATE
    } t_cell_op;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } t_state;

endpackage

// ===== hdl/blsw_in_if.sv =====
// Request channel: valid/ready handshake carrying operation and value.
// Depends on blsw_pkg for payload widths.
interface blsw_in_if;
    logic                               valid;
    logic                               ready;
    logic [blsw_pkg::OP_W-1:0]          operation;
    logic signed [blsw_pkg::DATA_W-1:0] value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== hdl/blsw_out_if.sv =====
// Result channel: valid/ready handshake carrying status, search result and list summary.
// Depends on blsw_pkg for payload widths.
interface blsw_out_if;
    logic                               valid;
    logic                               ready;
    logic [blsw_pkg::STATUS_W-1:0]      status;
    logic                               found;
    logic [blsw_pkg::POS_W-1:0]         position;
    logic [blsw_pkg::COUNT_W-1:0]       count;
    logic signed [blsw_pkg::DATA_W-1:0] head_value;
    logic signed [blsw_pkg::DATA_W-1:0] tail_value;

    modport source (
        output valid, output status, output found, output position,
        output count, output head_value, output tail_value, input ready
    );
    modport sink (
        input valid, input status, input found, input position,
        input count, input head_value, input tail_value, output ready
    );
endinterface

// ===== hdl/bounded_list_with_search_core.sv =====
// Top level of the bounded list with search: cell row plus sequencer.
// Depends on blsw_pkg, blsw_in_if, blsw_out_if and blsw_cell.

// The list is a row of CAPACITY cells with the head in cell 0. Insert at head
// shifts the row toward the tail, remove shifts it toward the head, append
// writes the cell just past the last entry. Each of these goes from the accepted
// request to S_FINISH and then into the output register. A search rotates the
// occupied cells past cell 0 one step per cycle, comparing there, and ends with
// the list back in order. One request is worked on at a time; a finished result
// waits in the output register while the next request is taken. No cell is
// cleared at reset.
module bounded_list_with_search_core #(
    parameter int CAPACITY = blsw_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blsw_in_if.sink     i_in,
    blsw_out_if.source  o_out
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Cell row
    logic signed [blsw_pkg::DATA_W-1:0] w_cell [CAPACITY];
    blsw_pkg::t_cell_op                 w_cell_op;
    logic [IW-1:0]                      w_sel;

    // Sequencer and list bookkeeping
    blsw_pkg::t_state                   r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic signed [blsw_pkg::DATA_W-1:0] r_tail, n_tail;
    logic signed [blsw_pkg::DATA_W-1:0] r_key, n_key;
    blsw_pkg::t_status                  r_status, n_status;
    logic                               r_found, n_found;
    logic [IW-1:0]                      r_pos, n_pos;
    logic [IW-1:0]                      r_step, n_step;

    // Output register
    logic                               r_out_valid, n_out_valid;
    logic [blsw_pkg::STATUS_W-1:0]      r_out_status, n_out_status;
    logic                               r_out_found, n_out_found;
    logic [blsw_pkg::POS_W-1:0]         r_out_pos, n_out_pos;
    logic [blsw_pkg::COUNT_W-1:0]       r_out_count, n_out_count;
    logic signed [blsw_pkg::DATA_W-1:0] r_out_head, n_out_head;
    logic signed [blsw_pkg::DATA_W-1:0] r_out_tail, n_out_tail;

    logic                               w_accept;
    logic                               w_full;
    logic                               w_empty;
    logic [IW-1:0]                      w_last;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [blsw_pkg::DATA_W-1:0] w_left;
            logic signed [blsw_pkg::DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = i_in.value;
            end else begin : g_inner_l
                assign w_left = w_cell[g-1];
            end
            if (g == CAPACITY - 1) begin : g_end
                assign w_right = w_cell[g];
            end else begin : g_inner_r
                assign w_right = w_cell[g+1];
            end
            blsw_cell #(
                .INDEX (g),
                .IW    (IW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cell_op),
                .i_sel   (w_sel),
                .i_left  (w_left),
                .i_right (w_right),
                .i_head  (w_cell[0]),
                .i_value (i_in.value),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    assign i_in.ready = (r_state == blsw_pkg::S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_last     = IW'(r_count - CW'(1));

    // Next state, cell command and result capture
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_tail       = r_tail;
        n_key        = r_key;
        n_status     = r_status;
        n_found      = r_found;
        n_pos        = r_pos;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        n_out_head   = r_out_head;
        n_out_tail   = r_out_tail;
        w_cell_op    = blsw_pkg::CELL_HOLD;
        w_sel        = IW'(r_count);

        case (r_state)
            blsw_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_found  = 1'b0;
                    n_pos    = '0;
                    n_status = blsw_pkg::ST_DONE;
                    n_state  = blsw_pkg::S_FINISH;
                    case (blsw_pkg::t_op'(i_in.operation))
                        blsw_pkg::OP_HEAD: begin
                            if (w_full) begin
                                n_status = blsw_pkg::ST_FULL;
                            end else begin
                                w_cell_op = blsw_pkg::CELL_SHIFT_IN;
                                n_count   = r_count + CW'(1);
                                if (w_empty) begin
                                    n_tail = i_in.value;
                                end
                            end
                        end
                        blsw_pkg::OP_TAIL: begin
                            if (w_full) begin
                                n_status = blsw_pkg::ST_FULL;
                            end else begin
                                w_cell_op = blsw_pkg::CELL_APPEND;
                                n_count   = r_count + CW'(1);
                                n_tail    = i_in.value;
                            end
                        end
                        blsw_pkg::OP_DROP: begin
                            if (w_empty) begin
                                n_status = blsw_pkg::ST_EMPTY;
                            end else begin
                                w_cell_op = blsw_pkg::CELL_SHIFT_OUT;
                                n_count   = r_count - CW'(1);
                            end
                        end
                        blsw_pkg::OP_FIND: begin
                            n_key  = i_in.value;
                            n_step = '0;
                            if (!w_empty) begin
                                n_state = blsw_pkg::S_SEARCH;
                            end
                        end
                        default: begin
                            n_state = blsw_pkg::S_FINISH;
                        end
                    endcase
                end
            end

            // Rotate one step, compare the entry now at the head
            blsw_pkg::S_SEARCH: begin
                w_cell_op = blsw_pkg::CELL_ROTATE;
                w_sel     = w_last;
                if ((w_cell[0] == r_key) && !r_found) begin
                    n_found = 1'b1;
                    n_pos   = r_step;
                end
                n_step = r_step + IW'(1);
                if (r_step == w_last) begin
                    n_state = blsw_pkg::S_FINISH;
                end
            end

            // Load the result once the output register is free
            blsw_pkg::S_FINISH: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_pos    = blsw_pkg::POS_W'(r_pos);
                    n_out_count  = blsw_pkg::COUNT_W'(r_count);
                    n_out_head   = w_empty ? '0 : w_cell[0];
                    n_out_tail   = w_empty ? '0 : r_tail;
                    n_state      = blsw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = blsw_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blsw_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_tail       <= n_tail;
        r_key        <= n_key;
        r_status     <= n_status;
        r_found      <= n_found;
        r_pos        <= n_pos;
        r_step       <= n_step;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
        r_out_head   <= n_out_head;
        r_out_tail   <= n_out_tail;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out_status;
    assign o_out.found      = r_out_found;
    assign o_out.position   = r_out_pos;
    assign o_out.count      = r_out_count;
    assign o_out.head_value = r_out_head;
    assign o_out.tail_value = r_out_tail;

endmodule

// ===== hdl/blsw_cell.sv =====
// One storage cell of the list row; position INDEX counted from the head.
// Depends on blsw_pkg for the cell command type and data width.
module blsw_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 4
) (
    input  logic                               i_clk,
    input  blsw_pkg::t_cell_op                 i_cmd,
    input  logic [IW-1:0]                      i_sel,
    input  logic signed [blsw_pkg::DATA_W-1:0] i_left,
    input  logic signed [blsw_pkg::DATA_W-1:0] i_right,
    input  logic signed [blsw_pkg::DATA_W-1:0] i_head,
    input  logic signed [blsw_pkg::DATA_W-1:0] i_value,
    output logic signed [blsw_pkg::DATA_W-1:0] o_data
);

    logic signed [blsw_pkg::DATA_W-1:0] r_data;
    logic signed [blsw_pkg::DATA_W-1:0] n_data;
    logic                               w_hit;

    assign w_hit = (i_sel == IW'(INDEX));

    // Next value from the broadcast command
    always_comb begin
        case (i_cmd)
            blsw_pkg::CELL_SHIFT_IN:  n_data = i_left;
            blsw_pkg::CELL_SHIFT_OUT: n_data = i_right;
            blsw_pkg::CELL_APPEND:    n_data = w_hit ? i_value : r_data;
            // last occupied cell wraps the head around, others pull from the right
            blsw_pkg::CELL_ROTATE:    n_data = w_hit ? i_head : i_right;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
